@@ hdl/assert_macros.svh @@
// Assertion macros shared by the segmenter RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// prop must hold at every rising clock edge outside reset
`define EPSEG_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("epseg assertion failed");
// cond must never be true at a rising clock edge outside reset
`define EPSEG_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("epseg forbidden condition");
`else
`define EPSEG_ASSERT(lbl, clk, rstn, prop)
`define EPSEG_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ hdl/epseg_pkg.sv @@
package epseg_pkg;

    localparam int FIELD_W     = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int OUT_DATA_W  = 3 * FIELD_W;
    localparam int OUT_USER_W  = 2;

    localparam logic [7:0]         NEWLINE_BYTE = 8'h0A;
    localparam logic [FIELD_W-1:0] CNT_MAX      = 16'hFFFF;

    typedef enum logic [1:0] {
        RULE_GLOBAL = 2'd0,
        RULE_RISE   = 2'd1,
        RULE_EITHER = 2'd2,
        RULE_NONE   = 2'd3
    } rule_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RESET_ON_NEWLINE    = 3'd0,
        CFG_MAX_PATCH_LENGTH    = 3'd1,
        CFG_RULE_MODE           = 3'd2,
        CFG_THRESHOLD_GLOBAL    = 3'd3,
        CFG_THRESHOLD_MONOTONIC = 3'd4,
        CFG_PATCH_CAP           = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [FIELD_W-1:0] first_pos;
        logic [FIELD_W-1:0] run_len;
        logic [FIELD_W-1:0] top_entropy;
        logic               patch_valid;
        logic               truncated;
        logic               last_patch;
    } res_t;

    // one queue entry: the results caused by one item
    typedef struct packed {
        res_t first;
        res_t second;
        logic two;
    } rec_t;

endpackage

@@ hdl/epseg_front.sv @@
module epseg_front #(
    parameter int ENTROPY_BITS  = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [epseg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [epseg_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  in_valid,
    input  logic                                  q_full,
    input  logic [ENTROPY_BITS-1:0]               entropy,
    input  logic [7:0]                            byte_value,
    input  logic                                  byte_known,
    input  logic                                  final_item,
    output logic                                  push,
    output epseg_pkg::rec_t                       rec
);

    localparam int FW     = epseg_pkg::FIELD_W;
    localparam int RISE_W = (ENTROPY_BITS + 1 > 17) ? ENTROPY_BITS + 1 : 17;
    localparam int GLB_W  = (ENTROPY_BITS > FW) ? ENTROPY_BITS : FW;

    // configuration
    logic                          rst_nl_reg;
    logic [FW-1:0]                 max_len_reg;
    epseg_pkg::rule_mode_t         rule_reg;
    logic [FW-1:0]                 thr_glb_reg;
    logic signed [16:0]            thr_mono_reg;
    logic [FW-1:0]                 patch_cap_reg;

    // sequence state
    logic [POSITION_BITS-1:0]      pos_reg,    pos_next;
    logic [POSITION_BITS-1:0]      start_reg,  start_next;
    logic [FW-1:0]                 len_reg,    len_next;
    logic [ENTROPY_BITS-1:0]       peak_reg,   peak_next;
    logic [ENTROPY_BITS-1:0]       prev_reg,   prev_next;
    logic [FW-1:0]                 emit_reg,   emit_next;
    logic                          in_seq_reg, in_seq_next;
    logic                          limit_reg,  limit_next;

    logic                          accept;
    logic                          nl_hit;
    logic                          len_hit;
    logic                          glb_hit;
    logic                          mono_hit;
    logic                          rule_hit;
    logic                          boundary;
    logic                          emit_close;
    logic                          final_ok;
    logic signed [ENTROPY_BITS:0]  rise;
    logic signed [RISE_W-1:0]      rise_ext;
    logic signed [RISE_W-1:0]      thr_ext;
    logic [POSITION_BITS+FW-1:0]   old_start_ext;
    logic [POSITION_BITS+FW-1:0]   new_start_ext;
    logic [ENTROPY_BITS+FW-1:0]    old_peak_ext;
    logic [ENTROPY_BITS+FW-1:0]    new_peak_ext;
    epseg_pkg::res_t               closed_res;
    epseg_pkg::res_t               final_res;

    assign accept = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rst_nl_reg    <= 1'b0;
            max_len_reg   <= 16'd16;
            rule_reg      <= epseg_pkg::RULE_GLOBAL;
            thr_glb_reg   <= 16'd8192;
            thr_mono_reg  <= '0;
            patch_cap_reg <= 16'hFFFF;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                epseg_pkg::CFG_RESET_ON_NEWLINE:    rst_nl_reg    <= cfg_data[0];
                epseg_pkg::CFG_MAX_PATCH_LENGTH:    max_len_reg   <= cfg_data[FW-1:0];
                epseg_pkg::CFG_RULE_MODE:
                    rule_reg <= epseg_pkg::rule_mode_t'(cfg_data[1:0]);
                epseg_pkg::CFG_THRESHOLD_GLOBAL:    thr_glb_reg   <= cfg_data[FW-1:0];
                epseg_pkg::CFG_THRESHOLD_MONOTONIC: thr_mono_reg  <= $signed(cfg_data);
                epseg_pkg::CFG_PATCH_CAP:           patch_cap_reg <= cfg_data[FW-1:0];
                default: ;
            endcase
        end
    end

    // boundary tests
    always_comb
    begin
        nl_hit   = byte_known && rst_nl_reg && (byte_value == epseg_pkg::NEWLINE_BYTE);
        len_hit  = len_reg >= max_len_reg;
        glb_hit  = GLB_W'(entropy) > GLB_W'(thr_glb_reg);
        rise     = $signed({1'b0, entropy}) - $signed({1'b0, prev_reg});
        rise_ext = RISE_W'(rise);
        thr_ext  = RISE_W'(thr_mono_reg);
        mono_hit = rise_ext > thr_ext;
        unique case (rule_reg)
            epseg_pkg::RULE_GLOBAL: rule_hit = glb_hit;
            epseg_pkg::RULE_RISE:   rule_hit = mono_hit;
            epseg_pkg::RULE_EITHER: rule_hit = glb_hit || mono_hit;
            epseg_pkg::RULE_NONE:   rule_hit = 1'b0;
        endcase
        boundary = nl_hit || len_hit || rule_hit;
    end

    // state update for one accepted item
    always_comb
    begin
        pos_next    = pos_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        peak_next   = peak_reg;
        prev_next   = prev_reg;
        emit_next   = emit_reg;
        in_seq_next = in_seq_reg;
        limit_next  = limit_reg;
        emit_close  = 1'b0;

        if (accept)
        begin
            prev_next = entropy;
            if (!in_seq_reg)
            begin
                in_seq_next = 1'b1;
                limit_next  = 1'b0;
                pos_next    = '0;
                start_next  = '0;
                len_next    = 16'd1;
                peak_next   = entropy;
                emit_next   = '0;
            end
            else
            begin
                if (pos_reg != '1)
                    pos_next = pos_reg + 1'b1;
                if (!limit_reg)
                begin
                    if (boundary)
                    begin
                        if (emit_reg >= patch_cap_reg)
                            limit_next = 1'b1;
                        else
                        begin
                            emit_close = 1'b1;
                            if (emit_reg != epseg_pkg::CNT_MAX)
                                emit_next = emit_reg + 1'b1;
                            start_next = pos_next;
                            len_next   = 16'd1;
                            peak_next  = entropy;
                        end
                    end
                    else
                    begin
                        if (len_reg != epseg_pkg::CNT_MAX)
                            len_next = len_reg + 1'b1;
                        if (entropy > peak_reg)
                            peak_next = entropy;
                    end
                end
            end
            if (final_item)
                in_seq_next = 1'b0;
        end
    end

    // result records
    always_comb
    begin
        old_start_ext = {{FW{1'b0}}, start_reg};
        new_start_ext = {{FW{1'b0}}, start_next};
        old_peak_ext  = {{FW{1'b0}}, peak_reg};
        new_peak_ext  = {{FW{1'b0}}, peak_next};
        final_ok      = !limit_next && (emit_next < patch_cap_reg);

        closed_res.first_pos   = old_start_ext[FW-1:0];
        closed_res.run_len     = len_reg;
        closed_res.top_entropy = old_peak_ext[FW-1:0];
        closed_res.patch_valid = 1'b1;
        closed_res.truncated   = 1'b0;
        closed_res.last_patch  = 1'b0;

        if (final_ok)
        begin
            final_res.first_pos   = new_start_ext[FW-1:0];
            final_res.run_len     = len_next;
            final_res.top_entropy = new_peak_ext[FW-1:0];
            final_res.patch_valid = 1'b1;
            final_res.truncated   = 1'b0;
        end
        else
        begin
            final_res.first_pos   = '0;
            final_res.run_len     = '0;
            final_res.top_entropy = '0;
            final_res.patch_valid = 1'b0;
            final_res.truncated   = 1'b1;
        end
        final_res.last_patch = 1'b1;

        push = accept && (emit_close || final_item);
        if (emit_close)
        begin
            rec.first  = closed_res;
            rec.second = final_res;
            rec.two    = final_item;
        end
        else
        begin
            rec.first  = final_res;
            rec.second = final_res;
            rec.two    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            peak_reg   <= '0;
            prev_reg   <= '0;
            emit_reg   <= '0;
            in_seq_reg <= 1'b0;
            limit_reg  <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            peak_reg   <= peak_next;
            prev_reg   <= prev_next;
            emit_reg   <= emit_next;
            in_seq_reg <= in_seq_next;
            limit_reg  <= limit_next;
        end
    end

`include "assert_macros.svh"

    // a sequence only ends on an accepted final item
    `EPSEG_ASSERT(a_seq_end, clk, rst_n, $fell(in_seq_reg) |-> $past(accept && final_item))

endmodule

@@ hdl/epseg_queue.sv @@
module epseg_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  epseg_pkg::rec_t push_rec,
    input  logic            pop,
    output epseg_pkg::rec_t head,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    epseg_pkg::rec_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;

    assign full  = cnt_reg == CNT_W'(DEPTH);
    assign empty = cnt_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`include "assert_macros.svh"

    `EPSEG_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && empty)
    `EPSEG_ASSERT_NEVER(a_push_full, clk, rst_n, push && full && !pop)

endmodule

@@ hdl/epseg_back.sv @@
module epseg_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  epseg_pkg::rec_t                     head,
    input  logic                                q_empty,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output epseg_pkg::res_t                     out_res
);

    logic            sel_reg,   sel_next;
    logic            valid_reg, valid_next;
    epseg_pkg::res_t res_reg,   res_next;
    logic            load;
    logic            take;

    // output register is free when empty or being taken this cycle
    always_comb
    begin
        load       = !valid_reg || out_ready;
        take       = load && !q_empty;
        pop        = take && (sel_reg || !head.two);
        sel_next   = sel_reg;
        valid_next = valid_reg;
        res_next   = res_reg;
        if (take)
        begin
            sel_next   = !sel_reg && head.two;
            valid_next = 1'b1;
            res_next   = sel_reg ? head.second : head.first;
        end
        else if (load)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg   <= sel_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

`include "assert_macros.svh"

    // second slot is pending only while its record still sits at the head
    `EPSEG_ASSERT(a_sel_head, clk, rst_n, sel_reg |-> (!q_empty && head.two))

endmodule

@@ hdl/entropy_patch_segmenter.sv @@
// Entropy patch segmenter.
// s_axis carries one byte per item: tdata = {byte_value, entropy}, tuser =
// byte_known, tlast = final item of the sequence. m_axis carries one patch
// per item: tdata = {top entropy, run length, first position}, tuser =
// {truncated, patch_valid}, tlast = last result of the sequence.
// The cfg channel writes one register per handshake (index, data); cfg_ready
// is always high. Write it only while the block is idle.
// Throughput: one input item per cycle while the queue is not full. A final
// item that also closes a patch yields two results, which the result side
// sends one after the other; every other item yields zero or one.
// Path: an accepted item's results go into a queue slot, then into the
// output register, and from there onto m_axis.
// The front stage updates patch state at one item a cycle unless the queue is
// full, and writes result records into a QUEUE_DEPTH-entry queue that the
// back stage drains. When m_axis stalls the queue fills and s_axis_tready drops.
// Reset returns the registers to their defaults, empties the queue and waits
// for the first item of a new sequence.
module entropy_patch_segmenter #(
    parameter int ENTROPY_BITS  = 16,
    parameter int POSITION_BITS = 16,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [epseg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [epseg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // entropy, byte_value, zero fill
    input  logic [((ENTROPY_BITS+15)/8)*8-1:0]   s_axis_tdata,
    // byte_known
    input  logic                                 s_axis_tuser,
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // first position, run length, top entropy
    output logic [epseg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // patch_valid, truncated
    output logic [epseg_pkg::OUT_USER_W-1:0]     m_axis_tuser,
    output logic                                 m_axis_tlast
);

    logic            q_full;
    logic            q_empty;
    logic            push;
    logic            pop;
    epseg_pkg::rec_t push_rec;
    epseg_pkg::rec_t head;
    epseg_pkg::res_t out_res;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !q_full;

    epseg_front #(
        .ENTROPY_BITS  (ENTROPY_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .q_full     (q_full),
        .entropy    (s_axis_tdata[ENTROPY_BITS-1:0]),
        .byte_value (s_axis_tdata[ENTROPY_BITS +: 8]),
        .byte_known (s_axis_tuser),
        .final_item (s_axis_tlast),
        .push       (push),
        .rec        (push_rec)
    );

    epseg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    epseg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {out_res.top_entropy, out_res.run_len, out_res.first_pos};
    assign m_axis_tuser = {out_res.truncated, out_res.patch_valid};
    assign m_axis_tlast = out_res.last_patch;

endmodule
